FILE: rtl/lsq_pkg.sv
// Package for the largest-square block: item types and field widths.
`default_nettype none

package lsq_pkg;

	localparam int SIDE_W = 11;
	localparam int AREA_W = 21;
	localparam int ROW_WIDTH_RESET = 1024;

	typedef struct packed {
		logic pixel;
		logic last_of_image;
	} pixel_item_t;

	typedef struct packed {
		logic [SIDE_W-1:0] largest_side;
		logic [AREA_W-1:0] largest_area;
	} result_item_t;

endpackage

`default_nettype wire

FILE: rtl/lsq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lsq_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/largest_square_of_ones.sv
// Top level: largest all-ones square in a raster-order binary image.
//
// Pixels enter on the pixel channel (pixel_valid / pixel_stall / pixel_item),
// one item per cycle while pixel_stall is low, in rows of row_width pixels;
// row_width is written on cfg_we / cfg_wdata; the user must write it only while
// the block is idle, as the block does not enforce this. A width of zero acts as
// one and a width above MAX_COLS acts as MAX_COLS. The row store is a RAM read
// at the edge that takes a pixel and written in the next cycle from the compute
// stage; with a one-pixel row the value just written is forwarded.
// The item marked last_of_image yields one result item (largest side and
// area) via the output register or skid; the image state then starts afresh.
// Results wait in an output register backed by a one-entry skid register, so
// pixels keep flowing while a result is stalled; pixel_stall rises only while
// a last pixel is in flight and a result already waits, or the skid is full.
// Reset clears the control state and sets row_width to 1024; the row store is
// not cleared, since values read in the first row of an image are not used.
`default_nettype none

module largest_square_of_ones
	import lsq_pkg::*;
#(
	parameter int MAX_COLS = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [SIDE_W-1:0] cfg_wdata,
	input  wire logic              pixel_valid,
	output logic                   pixel_stall,
	input  wire pixel_item_t       pixel_item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output result_item_t           result_item
);

	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int EW = ($clog2(MAX_COLS + 1) > SIDE_W) ? $clog2(MAX_COLS + 1) : SIDE_W;

	logic [SIDE_W-1:0] row_width_q;
	logic [AW-1:0]     col_q;
	logic              first_q;
	logic [SIDE_W-1:0] left_q;
	logic [SIDE_W-1:0] diag_q;
	logic [SIDE_W-1:0] best_q;

	logic              valid_s1;
	logic [AW-1:0]     col_s1;
	logic              pixel_s1;
	logic              last_s1;
	logic              first_s1;
	logic              col0_s1;
	logic              fwd_s1;
	logic [SIDE_W-1:0] fwd_side_s1;

	logic              out_valid_q;
	logic [SIDE_W-1:0] out_side_q;
	logic              skid_valid_q;
	logic [SIDE_W-1:0] skid_side_q;

	logic [EW-1:0]     eff_w;
	logic [EW-1:0]     row_w_ext;
	logic              wrap_now;
	logic [AW-1:0]     col_front;
	logic              first_front;
	logic [EW-1:0]     col_inc;
	logic              wrap_next;
	logic [AW-1:0]     col_next;
	logic              first_next;
	logic              accept;

	logic [SIDE_W-1:0] rdata;
	logic [SIDE_W-1:0] above;
	logic [SIDE_W-1:0] left_v;
	logic [SIDE_W-1:0] diag_v;
	logic [SIDE_W-1:0] min_ld;
	logic [SIDE_W-1:0] min3;
	logic [SIDE_W-1:0] side;
	logic [SIDE_W-1:0] res_side;
	logic              res_event;
	logic [2*SIDE_W-1:0] area_full;

	// effective row width
	always_comb begin
		row_w_ext = EW'(row_width_q);
		if (row_width_q == '0) begin
			eff_w = EW'(1);
		end else if (row_w_ext > EW'(MAX_COLS)) begin
			eff_w = EW'(MAX_COLS);
		end else begin
			eff_w = row_w_ext;
		end
	end

	always_comb begin
		wrap_now    = EW'(col_q) >= eff_w;
		col_front   = wrap_now ? '0 : col_q;
		first_front = first_q && !wrap_now;
		col_inc     = EW'(col_front) + EW'(1);
		wrap_next   = col_inc >= eff_w;
		col_next    = wrap_next ? '0 : col_inc[AW-1:0];
		first_next  = first_front && !wrap_next;
	end

	assign pixel_stall = skid_valid_q || (valid_s1 && last_s1 && out_valid_q);
	assign accept      = pixel_valid && !pixel_stall;

	lsq_ram #(
		.WIDTH(SIDE_W),
		.DEPTH(MAX_COLS)
	) u_row_ram (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(col_s1),
		.wdata(side),
		.re   (accept),
		.raddr(col_front),
		.rdata(rdata)
	);

	always_comb begin
		above     = first_s1 ? '0 : (fwd_s1 ? fwd_side_s1 : rdata);
		left_v    = col0_s1 ? '0 : left_q;
		diag_v    = (first_s1 || col0_s1) ? '0 : diag_q;
		min_ld    = (left_v < diag_v) ? left_v : diag_v;
		min3      = (above < min_ld) ? above : min_ld;
		side      = pixel_s1 ? (min3 + SIDE_W'(1)) : '0;
		res_side  = (side > best_q) ? side : best_q;
		res_event = valid_s1 && last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= SIDE_W'(ROW_WIDTH_RESET);
		end else if (cfg_we) begin
			row_width_q <= cfg_wdata;
		end
	end

	// front end: column tracking and stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			first_q  <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (pixel_item.last_of_image) begin
					col_q   <= '0;
					first_q <= 1'b1;
				end else begin
					col_q   <= col_next;
					first_q <= first_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= col_front;
			pixel_s1    <= pixel_item.pixel;
			last_s1     <= pixel_item.last_of_image;
			first_s1    <= first_front;
			col0_s1     <= col_front == '0;
			fwd_s1      <= valid_s1 && (col_s1 == col_front);
			fwd_side_s1 <= side;
		end
	end

	// neighbour and best-side state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			diag_q <= '0;
			best_q <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				left_q <= '0;
				diag_q <= '0;
				best_q <= '0;
			end else begin
				left_q <= side;
				diag_q <= above;
				best_q <= res_side;
			end
		end
	end

	// output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !result_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_event;
			end
		end else if (res_event) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !result_stall) begin
			if (skid_valid_q) begin
				out_side_q <= skid_side_q;
			end else if (res_event) begin
				out_side_q <= res_side;
			end
		end else if (res_event) begin
			skid_side_q <= res_side;
		end
	end

	assign area_full                = (2*SIDE_W)'(out_side_q) * (2*SIDE_W)'(out_side_q);
	assign result_valid             = out_valid_q;
	assign result_item.largest_side = out_side_q;
	assign result_item.largest_area = area_full[AREA_W-1:0];

endmodule

`default_nettype wire
